[hw/rtl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants, codes and controller/datapath interface types for the
// periodic tick task table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  // default sizes
  localparam int SLOTS_DEF       = 10;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  // fixed port widths
  localparam int OP_W       = 2;
  localparam int ID_PORT_W  = 8;
  localparam int PER_PORT_W = 16;
  localparam int SLOT_W     = 5;
  localparam int STATUS_W   = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // result kinds
  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL     = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request, restart slot scan
    logic tick_step;   // apply tick to current slot, advance
    logic find_step;   // look up id in current slot, advance
    logic put_status;  // update table and load status result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_tick;
    logic op_skip;
    logic op_null;
    logic last_slot;
    logic slot_due;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/ptt_ctrl.sv]
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer for the task table: accepts a request, walks the slots one per
// cycle unless a due slot stalls, and hands out commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ptt_pkg::sts_t sts,
  output ptt_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_TICK     = 3'd2;
  localparam logic [2:0] S_FIND     = 3'd3;
  localparam logic [2:0] S_STATUS   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op_skip) begin
          state_next = S_IDLE;
        end else if (sts.op_tick) begin
          state_next = S_TICK;
        end else if (sts.op_null) begin
          state_next = S_STATUS;
        end else begin
          state_next = S_FIND;
        end
      end
      S_TICK: begin
        // a due slot waits until the result register can take it
        if (!sts.slot_due || sts.out_free) begin
          cmd.tick_step = 1'b1;
          if (sts.last_slot) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.last_slot) begin
          state_next = S_STATUS;
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.put_status = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ptt_datapath.sv]
// ----------------------------------------------------------------------------
// ptt_datapath
// Slot table, request registers, scan index, lookup results and the output
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_datapath #(
  parameter int SLOTS       = ptt_pkg::SLOTS_DEF,
  parameter int PERIOD_BITS = ptt_pkg::PERIOD_BITS_DEF,
  parameter int ID_BITS     = ptt_pkg::ID_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [ptt_pkg::OP_W-1:0]       operation,
  input  wire logic [ptt_pkg::ID_PORT_W-1:0]  task_id,
  input  wire logic [ptt_pkg::PER_PORT_W-1:0] period_ms,
  input  wire logic                           out_stall,
  input  wire ptt_pkg::cmd_t                  cmd,
  output ptt_pkg::sts_t                       sts,
  output logic                                out_valid,
  output logic                                kind,
  output logic [ptt_pkg::ID_PORT_W-1:0]       fired_task,
  output logic [ptt_pkg::SLOT_W-1:0]          slot_index,
  output logic [ptt_pkg::STATUS_W-1:0]        status,
  output logic                                last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
  localparam logic [31:0] PMAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);

  // slot table
  logic                   slot_valid     [SLOTS];
  logic [ID_BITS-1:0]     slot_task      [SLOTS];
  logic [PERIOD_BITS-1:0] slot_period    [SLOTS];
  logic [PERIOD_BITS-1:0] slot_countdown [SLOTS];

  // request
  logic [ptt_pkg::OP_W-1:0] op_reg;
  logic [ID_BITS-1:0]       id_reg;
  logic [PERIOD_BITS-1:0]   per_reg;

  // scan
  logic [IDX_W-1:0] idx;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic [SLOTS-1:0]             due;
  logic [SLOTS-1:0]             due_above;
  logic                         cur_valid;
  logic                         cur_due;
  logic [31:0]                  per_wide;
  logic [31:0]                  per_sat;
  logic                         is_add;
  logic                         do_insert;
  logic                         do_remove;
  logic                         load_out;
  logic                         res_kind;
  logic [ptt_pkg::ID_PORT_W-1:0] res_id;
  logic [ptt_pkg::SLOT_W-1:0]    res_slot;
  logic [ptt_pkg::STATUS_W-1:0]  res_status;
  logic                         res_last;

  // period clamp into 1 .. 2^PERIOD_BITS-1
  always_comb begin
    per_wide = 32'(period_ms);
    if (per_wide == 32'd0) begin
      per_sat = 32'd1;
    end else if (per_wide > PMAX) begin
      per_sat = PMAX;
    end else begin
      per_sat = per_wide;
    end
  end

  // due flags per slot, and whether any slot past the scan index is due
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      due[j]       = slot_valid[j] && (slot_countdown[j] <= PERIOD_BITS'(1));
      due_above[j] = due[j] && (IDX_W'(j) > idx);
    end
  end

  assign cur_valid = slot_valid[idx];
  assign cur_due   = due[idx];
  assign is_add    = (op_reg == ptt_pkg::OP_ADD);
  assign do_insert = cmd.put_status && is_add && (id_reg != '0) && !hit_found && free_found;
  assign do_remove = cmd.put_status && (op_reg == ptt_pkg::OP_REMOVE) && (id_reg != '0)
                     && hit_found;
  assign load_out  = (cmd.tick_step && cur_due) || cmd.put_status;

  always_comb begin
    sts.op_tick   = (op_reg == ptt_pkg::OP_TICK);
    sts.op_skip   = (op_reg == ptt_pkg::OP_NONE);
    sts.op_null   = (id_reg == '0);
    sts.last_slot = (idx == IDX_LAST);
    sts.slot_due  = cur_due;
    sts.out_free  = !out_valid || !out_stall;
  end

  // next result
  always_comb begin
    res_kind   = ptt_pkg::KIND_STATUS;
    res_id     = ptt_pkg::ID_PORT_W'(id_reg);
    res_slot   = '0;
    res_status = ptt_pkg::ST_OK;
    res_last   = 1'b1;
    if (cmd.tick_step) begin
      res_kind = ptt_pkg::KIND_FIRE;
      res_id   = ptt_pkg::ID_PORT_W'(slot_task[idx]);
      res_slot = ptt_pkg::SLOT_W'(idx);
      res_last = ~|due_above;
    end else if (id_reg == '0) begin
      res_id     = '0;
      res_status = ptt_pkg::ST_NULL;
    end else if (is_add) begin
      if (hit_found) begin
        res_slot   = ptt_pkg::SLOT_W'(hit_idx);
        res_status = ptt_pkg::ST_DUP;
      end else if (free_found) begin
        res_slot = ptt_pkg::SLOT_W'(free_idx);
      end else begin
        res_status = ptt_pkg::ST_FULL;
      end
    end else begin
      if (hit_found) begin
        res_slot = ptt_pkg::SLOT_W'(hit_idx);
      end else begin
        res_status = ptt_pkg::ST_NOTFOUND;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      idx        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        slot_valid[j] <= 1'b0;
      end
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        idx        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.tick_step || cmd.find_step) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.find_step) begin
        if (cur_valid && (slot_task[idx] == id_reg) && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!cur_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (do_insert) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (do_remove) begin
        slot_valid[hit_idx] <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg  <= operation;
      id_reg  <= ID_BITS'(task_id);
      per_reg <= per_sat[PERIOD_BITS-1:0];
    end
    if (cmd.find_step) begin
      if (cur_valid && (slot_task[idx] == id_reg) && !hit_found) begin
        hit_idx <= idx;
      end
      if (!cur_valid && !free_found) begin
        free_idx <= idx;
      end
    end
    if (cmd.tick_step) begin
      if (cur_due) begin
        slot_countdown[idx] <= slot_period[idx];
      end else if (cur_valid) begin
        slot_countdown[idx] <= slot_countdown[idx] - PERIOD_BITS'(1);
      end
    end
    if (do_insert) begin
      slot_task[free_idx]      <= id_reg;
      slot_period[free_idx]    <= per_reg;
      slot_countdown[free_idx] <= PERIOD_BITS'(1);
    end
    if (load_out) begin
      kind       <= res_kind;
      fired_task <= res_id;
      slot_index <= res_slot;
      status     <= res_status;
      last       <= res_last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/periodic_tick_task_table_core.sv]
// ----------------------------------------------------------------------------
// periodic_tick_task_table_core
// Table of periodic tasks: tick requests fire due tasks in slot order, add and
// remove requests manage the table and return one status result each.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  -----------------------------------------
//   in       in_valid / in_stall  operation, task_id, period_ms
//   out      out_valid/ out_stall kind, fired_task, slot_index, status, last
//
// a tick runs dispatch then the slot scan, add and remove dispatch, scan and status,
// a null id dispatch and status; the scan visits one slot per cycle in the datapath
// a due slot waits in the scan while the output register is full and stalled
// a request is taken while the previous result still waits on the output
// reset frees every slot at once; slot ids and periods are written only on add
`default_nettype none

module periodic_tick_task_table_core #(
  parameter int SLOTS       = ptt_pkg::SLOTS_DEF,
  parameter int PERIOD_BITS = ptt_pkg::PERIOD_BITS_DEF,
  parameter int ID_BITS     = ptt_pkg::ID_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ptt_pkg::OP_W-1:0]       operation,
  input  wire logic [ptt_pkg::ID_PORT_W-1:0]  task_id,
  input  wire logic [ptt_pkg::PER_PORT_W-1:0] period_ms,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                kind,
  output logic [ptt_pkg::ID_PORT_W-1:0]       fired_task,
  output logic [ptt_pkg::SLOT_W-1:0]          slot_index,
  output logic [ptt_pkg::STATUS_W-1:0]        status,
  output logic                                last
);

  ptt_pkg::cmd_t cmd;
  ptt_pkg::sts_t sts;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptt_datapath #(
    .SLOTS       (SLOTS),
    .PERIOD_BITS (PERIOD_BITS),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .operation  (operation),
    .task_id    (task_id),
    .period_ms  (period_ms),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .kind       (kind),
    .fired_task (fired_task),
    .slot_index (slot_index),
    .status     (status),
    .last       (last)
  );

endmodule

`default_nettype wire

[verif/periodic_tick_task_table_checker.sv]
// ----------------------------------------------------------------------------
// periodic_tick_task_table_checker
// Watches both channels of the task table core. It keeps a shadow copy of the
// slot table, works out the fired and status results of every accepted
// request and compares each result leaving the block with the oldest one due.
// ----------------------------------------------------------------------------
module periodic_tick_task_table_checker #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [ptt_pkg::OP_W-1:0]       operation,
  input  logic [ptt_pkg::ID_PORT_W-1:0]  task_id,
  input  logic [ptt_pkg::PER_PORT_W-1:0] period_ms,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           kind,
  input  logic [ptt_pkg::ID_PORT_W-1:0]  fired_task,
  input  logic [ptt_pkg::SLOT_W-1:0]     slot_index,
  input  logic [ptt_pkg::STATUS_W-1:0]   status,
  input  logic                           last,
  output int                             mismatches,
  output int                             pending,
  output int                             fired_count,
  output int                             status_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                           kind;
    logic [ptt_pkg::ID_PORT_W-1:0]  id;
    logic [ptt_pkg::SLOT_W-1:0]     slot;
    logic [ptt_pkg::STATUS_W-1:0]   status;
    logic                           last;
  } table_result_t;

  // shadow of the slot table
  logic                           slot_busy      [SLOTS];
  logic [ptt_pkg::ID_PORT_W-1:0]  slot_owner     [SLOTS];
  logic [ptt_pkg::PER_PORT_W-1:0] slot_reload    [SLOTS];
  logic [ptt_pkg::PER_PORT_W-1:0] slot_remaining [SLOTS];

  table_result_t table_results[$];

  initial begin
    mismatches = 0;
    pending = 0;
    fired_count = 0;
    status_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_owner[i] = '0;
      slot_reload[i] = '0;
      slot_remaining[i] = '0;
    end
  end

  function automatic table_result_t make_status(logic [ptt_pkg::ID_PORT_W-1:0] id, int slot,
                                                logic [ptt_pkg::STATUS_W-1:0] code);
    table_result_t r;
    r.kind = ptt_pkg::KIND_STATUS;
    r.id = id;
    r.slot = ptt_pkg::SLOT_W'(slot);
    r.status = code;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic update_task_table(input logic [ptt_pkg::OP_W-1:0] op,
                                   input logic [ptt_pkg::ID_PORT_W-1:0] id,
                                   input logic [ptt_pkg::PER_PORT_W-1:0] per);
    int hit;
    int free_slot;
    int last_due;
    table_result_t r;
    hit = -1;
    free_slot = -1;
    last_due = -1;
    if (op == ptt_pkg::OP_TICK) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_busy[i] && slot_remaining[i] <= 1) last_due = i;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i]) begin
          if (slot_remaining[i] <= 1) begin
            r.kind = ptt_pkg::KIND_FIRE;
            r.id = slot_owner[i];
            r.slot = ptt_pkg::SLOT_W'(i);
            r.status = ptt_pkg::ST_OK;
            r.last = (i == last_due);
            table_results.push_back(r);
            slot_remaining[i] = slot_reload[i];
          end else begin
            slot_remaining[i] = slot_remaining[i] - 1'b1;
          end
        end
      end
    end else if (op != ptt_pkg::OP_NONE) begin
      if (id == '0) begin
        table_results.push_back(make_status('0, 0, ptt_pkg::ST_NULL));
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_busy[i] && slot_owner[i] == id) hit = i;
          if (!slot_busy[i]) free_slot = i;
        end
        if (op == ptt_pkg::OP_ADD) begin
          if (hit >= 0) begin
            table_results.push_back(make_status(id, hit, ptt_pkg::ST_DUP));
          end else if (free_slot >= 0) begin
            slot_busy[free_slot] = 1'b1;
            slot_owner[free_slot] = id;
            slot_reload[free_slot] = (per == '0) ? ptt_pkg::PER_PORT_W'(1) : per;
            slot_remaining[free_slot] = ptt_pkg::PER_PORT_W'(1);
            table_results.push_back(make_status(id, free_slot, ptt_pkg::ST_OK));
          end else begin
            table_results.push_back(make_status(id, 0, ptt_pkg::ST_FULL));
          end
        end else if (hit >= 0) begin
          slot_busy[hit] = 1'b0;
          table_results.push_back(make_status(id, hit, ptt_pkg::ST_OK));
        end else begin
          table_results.push_back(make_status(id, 0, ptt_pkg::ST_NOTFOUND));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    table_result_t seen;
    table_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) update_task_table(operation, task_id, period_ms);
      if (out_valid && !out_stall) begin
        seen = {kind, fired_task, slot_index, status, last};
        if (kind == ptt_pkg::KIND_FIRE) fired_count++;
        else status_count++;
        if (table_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind %0d id %0d slot %0d status %0d last %0d",
                     $realtime, seen.kind, seen.id, seen.slot, seen.status, seen.last);
        end else begin
          want = table_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  got      kind %0d id %0d slot %0d status %0d last %0d",
                       seen.kind, seen.id, seen.slot, seen.status, seen.last);
              $display("  expected kind %0d id %0d slot %0d status %0d last %0d",
                       want.kind, want.id, want.slot, want.status, want.last);
            end
          end
        end
      end
      pending = table_results.size();
    end
  end

endmodule

[verif/tb_periodic_tick_task_table_core.sv]
// ----------------------------------------------------------------------------
// tb_periodic_tick_task_table_core
// Drives tick, add and remove requests into the task table core with random
// gaps and output stalls. A directed opening covers null ids, duplicates, a
// full table and removal; random traffic then churns a small id pool.
// ----------------------------------------------------------------------------
module tb_periodic_tick_task_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ptt_pkg::OP_W-1:0]       operation = ptt_pkg::OP_TICK;
  logic [ptt_pkg::ID_PORT_W-1:0]  task_id = '0;
  logic [ptt_pkg::PER_PORT_W-1:0] period_ms = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           kind;
  logic [ptt_pkg::ID_PORT_W-1:0]  fired_task;
  logic [ptt_pkg::SLOT_W-1:0]     slot_index;
  logic [ptt_pkg::STATUS_W-1:0]   status;
  logic                           last;

  int mismatches;
  int pending;
  int fired_count;
  int status_count;
  int requests_sent = 0;

  // burst stretches with no idling on either side
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  always #5 clk = ~clk;

  periodic_tick_task_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .task_id   (task_id),
    .period_ms (period_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .fired_task(fired_task),
    .slot_index(slot_index),
    .status    (status),
    .last      (last)
  );

  periodic_tick_task_table_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .task_id     (task_id),
    .period_ms   (period_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .fired_task  (fired_task),
    .slot_index  (slot_index),
    .status      (status),
    .last        (last),
    .mismatches  (mismatches),
    .pending     (pending),
    .fired_count (fired_count),
    .status_count(status_count)
  );

  task automatic send_request(input logic [ptt_pkg::OP_W-1:0] op,
                              input logic [ptt_pkg::ID_PORT_W-1:0] id,
                              input logic [ptt_pkg::PER_PORT_W-1:0] per);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    task_id <= id;
    period_ms <= per;
    do @(posedge clk); while (in_stall);
    if (op != ptt_pkg::OP_NONE) requests_sent++;
  endtask

  // receiver: outside bursts, may stall after a taken result and sometimes while waiting
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      hold = 0;
      if (out_valid && !out_stall) begin
        if (!out_burst) hold = $urandom_range(0, 15);
      end else if (!out_burst && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 15);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int pick;
    logic [ptt_pkg::OP_W-1:0]       op;
    logic [ptt_pkg::ID_PORT_W-1:0]  id;
    logic [ptt_pkg::PER_PORT_W-1:0] per;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening
    send_request(ptt_pkg::OP_TICK, 8'h00, 16'h0000);    // empty table, nothing due
    send_request(ptt_pkg::OP_ADD, 8'h00, 16'h0003);     // null id
    send_request(ptt_pkg::OP_REMOVE, 8'h00, 16'h0000);
    send_request(ptt_pkg::OP_REMOVE, 8'h05, 16'h0000);  // absent id
    send_request(ptt_pkg::OP_ADD, 8'hFF, 16'h0000);     // zero period acts as one
    send_request(ptt_pkg::OP_ADD, 8'h01, 16'hFFFF);
    send_request(ptt_pkg::OP_ADD, 8'hFF, 16'h0002);     // duplicate
    send_request(ptt_pkg::OP_TICK, 8'hFF, 16'hFFFF);
    send_request(ptt_pkg::OP_TICK, 8'h00, 16'h0000);
    send_request(ptt_pkg::OP_NONE, 8'h3C, 16'hA5A5);    // unused code, no result
    for (int i = 2; i <= 9; i++)
      send_request(ptt_pkg::OP_ADD, ptt_pkg::ID_PORT_W'(i), ptt_pkg::PER_PORT_W'(i));
    send_request(ptt_pkg::OP_ADD, 8'h80, 16'h0004);     // table full
    send_request(ptt_pkg::OP_TICK, 8'h00, 16'h0000);
    send_request(ptt_pkg::OP_TICK, 8'h00, 16'h0000);
    send_request(ptt_pkg::OP_REMOVE, 8'h01, 16'h0000);
    send_request(ptt_pkg::OP_REMOVE, 8'hFF, 16'h0000);
    send_request(ptt_pkg::OP_ADD, 8'hAA, 16'h5555);     // lowest free slot reused
    send_request(ptt_pkg::OP_TICK, 8'h55, 16'hAAAA);

    // random traffic over a small id pool so duplicates and a full table recur
    while (requests_sent < 124) begin
      if (requests_sent % 16 == 0) begin
        in_burst = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) op = ptt_pkg::OP_TICK;
      else if (pick < 73) op = ptt_pkg::OP_ADD;
      else if (pick < 95) op = ptt_pkg::OP_REMOVE;
      else op = ptt_pkg::OP_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 6) id = '0;
      else if (pick < 80) id = ptt_pkg::ID_PORT_W'($urandom_range(1, 13));
      else id = ptt_pkg::ID_PORT_W'($urandom_range(1, 255));
      pick = $urandom_range(0, 99);
      if (pick < 70) per = ptt_pkg::PER_PORT_W'($urandom_range(0, 6));
      else if (pick < 90) per = ptt_pkg::PER_PORT_W'($urandom);
      else per = '1;
      send_request(op, id, per);
    end
    in_valid <= 1'b0;
    out_burst = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a tick with nothing due keeps the scan busy with no result to wait on
    repeat (40) @(posedge clk);

    $display("sent %0d requests; %0d fired results and %0d status results checked",
             requests_sent, fired_count, status_count);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_periodic_tick_task_table_core OK");
    end else begin
      $display("tb_periodic_tick_task_table_core NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_periodic_tick_task_table_core NOT OK");
    $finish;
  end

endmodule
